// File: rtl/fbfla_pkg.sv
// ----------------------------------------------------------------------------
// Free-list allocator package
// Shared types, widths and codes of the fixed-block free-list allocator.
// ----------------------------------------------------------------------------
package fbfla_pkg;

   localparam int IDX_W    = 8;   // block index field
   localparam int LINK_W   = 9;   // link entry, head and counters
   localparam int SIZE_W   = 13;  // object_size register
   localparam int CNT_W    = 9;   // object_count register and used_count
   localparam int STATUS_W = 2;
   localparam int OFFS_W   = 20;
   localparam int RSP_W    = 40;  // result fields padded to whole bytes

   localparam logic [LINK_W-1:0] FRESH_MARK = 9'd256;
   localparam logic [CNT_W-1:0]  USED_MAX   = 9'd511;

   // Result field positions inside rsp_tdata.
   localparam int RSP_STATUS_LSB = 0;
   localparam int RSP_GRANT_LSB  = RSP_STATUS_LSB + STATUS_W;
   localparam int RSP_OFFS_LSB   = RSP_GRANT_LSB + IDX_W;
   localparam int RSP_USED_LSB   = RSP_OFFS_LSB + OFFS_W;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic CSR_OBJECT_SIZE  = 1'b0;
   localparam logic CSR_OBJECT_COUNT = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_FINISH
   } state_type;

   // One access to the link RAM; reads and writes never share a cycle.
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [IDX_W-1:0]  addr;
      logic [LINK_W-1:0] wr_data;
   } link_req_type;

endpackage

// File: rtl/fixed_block_free_list_allocator.sv
// ----------------------------------------------------------------------------
// Fixed-block free-list allocator
// Pool allocator for equal-sized blocks kept as a LIFO free list.
// ----------------------------------------------------------------------------
// The req channel carries one request per item: req_tuser selects allocate
// or free, req_tdata gives the block index to free. The rsp channel returns
// one item per request with the status, the granted index, its byte offset
// and the number of blocks in use afterwards. The csr channel writes
// object_size (index 0) and object_count (index 1), is always ready, and the
// user must write it only while no request is in flight; no check is made.
// The accepting cycle of an allocate issues the registered read of the link
// RAM at the list head; the finishing state then updates the head and
// counters and loads the result register, which drives rsp_tvalid. Requests
// are taken one at a time: a new one is accepted only once the last has
// finished and the block is idle again.
// When rsp_tready is low the finished item waits in the result register;
// the block still accepts the next request, which then holds in its final
// cycle until the result register frees.
// Reset frees every block at once: indices never handed out come from a
// counter in ascending order, so the link RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator #(
   parameter int MAX_BLOCKS = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic                         req_tuser,   // [0] req_type
   input  logic [7:0]                   req_tdata,   // [7:0] block_index
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [1:0] status, [9:2] granted_index, [29:10] block_offset,
   // [38:30] used_count, [39] zero
   output logic [fbfla_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [fbfla_pkg::SIZE_W-1:0] csr_data
);

   localparam int POOL_DEPTH = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;

   logic [fbfla_pkg::SIZE_W-1:0] object_size_ff, object_size_in;
   logic [fbfla_pkg::CNT_W-1:0]  object_count_ff, object_count_in;
   fbfla_pkg::link_req_type      link_req;
   logic [fbfla_pkg::LINK_W-1:0] link_rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      object_size_in  = object_size_ff;
      object_count_in = object_count_ff;
      if (csr_valid) begin
         unique case (csr_index)
            fbfla_pkg::CSR_OBJECT_SIZE:  object_size_in  = csr_data;
            fbfla_pkg::CSR_OBJECT_COUNT: object_count_in = csr_data[fbfla_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         object_size_ff  <= 13'd8;
         object_count_ff <= 9'd256;
      end else begin
         object_size_ff  <= object_size_in;
         object_count_ff <= object_count_in;
      end
   end

   fbfla_engine #(
      .DEPTH(POOL_DEPTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tuser    (req_tuser),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .object_size  (object_size_ff),
      .object_count (object_count_ff),
      .link_req     (link_req),
      .rd_data      (link_rd_data)
   );

   fbfla_link_ram #(
      .DEPTH(POOL_DEPTH)
   ) u_link_ram (
      .clock    (clock),
      .link_req (link_req),
      .rd_data  (link_rd_data)
   );

endmodule

// File: rtl/fbfla_link_ram.sv
// ----------------------------------------------------------------------------
// Link RAM
// Single-port synchronous store of the next link of each freed block, with a
// registered read port.
// ----------------------------------------------------------------------------
module fbfla_link_ram #(
   parameter int DEPTH = 256
) (
   input  logic                           clock,
   input  fbfla_pkg::link_req_type        link_req,
   output logic [fbfla_pkg::LINK_W-1:0]   rd_data
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [fbfla_pkg::LINK_W-1:0] mem [DEPTH];
   logic [fbfla_pkg::LINK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (link_req.wr_en) begin
         mem[link_req.addr[ADDR_W-1:0]] <= link_req.wr_data;
      end
      if (link_req.rd_en) begin
         rd_data_ff <= mem[link_req.addr[ADDR_W-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/fbfla_engine.sv
// ----------------------------------------------------------------------------
// Allocator engine
// Takes one request at a time, reads (allocate) or writes (free) a link, then
// updates the head, fresh counter and use count and registers the result.
// ----------------------------------------------------------------------------
module fbfla_engine #(
   parameter int DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              req_tuser,
   input  logic [fbfla_pkg::IDX_W-1:0]       req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [fbfla_pkg::RSP_W-1:0]       rsp_tdata,
   input  logic [fbfla_pkg::SIZE_W-1:0]      object_size,
   input  logic [fbfla_pkg::CNT_W-1:0]       object_count,
   output fbfla_pkg::link_req_type           link_req,
   input  logic [fbfla_pkg::LINK_W-1:0]      rd_data
);

   localparam logic [fbfla_pkg::CNT_W-1:0] CAP = fbfla_pkg::CNT_W'(DEPTH);

   fbfla_pkg::state_type              state_ff, state_in;
   logic                              kind_ff, kind_in;
   logic [fbfla_pkg::IDX_W-1:0]       index_ff, index_in;
   logic [fbfla_pkg::LINK_W-1:0]      head_ff, head_in;
   logic [fbfla_pkg::LINK_W-1:0]      fresh_ff, fresh_in;
   logic [fbfla_pkg::CNT_W-1:0]       used_ff, used_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [fbfla_pkg::RSP_W-1:0]       rsp_data_ff, rsp_data_in;

   logic [fbfla_pkg::CNT_W-1:0]       usable;
   logic                              out_free;
   logic                              grant_ok;
   logic [fbfla_pkg::IDX_W-1:0]       grant;
   logic [fbfla_pkg::STATUS_W-1:0]    status;
   logic [fbfla_pkg::IDX_W+fbfla_pkg::SIZE_W-1:0] product;

   assign usable   = (object_count > CAP) ? CAP : object_count;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign product  = (fbfla_pkg::IDX_W + fbfla_pkg::SIZE_W)'(grant)
                   * (fbfla_pkg::IDX_W + fbfla_pkg::SIZE_W)'(object_size);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbfla_pkg::ST_IDLE;
         head_ff      <= fbfla_pkg::FRESH_MARK;
         fresh_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fresh_ff     <= fresh_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      index_ff    <= index_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      index_in     = index_ff;
      head_in      = head_ff;
      fresh_in     = fresh_ff;
      used_in      = used_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      grant_ok     = 1'b0;
      grant        = '0;
      status       = fbfla_pkg::STATUS_OK;
      link_req     = '0;

      unique case (state_ff)
         fbfla_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in  = req_tuser;
               index_in = req_tdata;
               state_in = fbfla_pkg::ST_FINISH;
               // Fetch the successor of the head so that a pop can complete.
               link_req.rd_en = (req_tuser == fbfla_pkg::REQ_ALLOC);
               link_req.addr  = head_ff[fbfla_pkg::IDX_W-1:0];
            end
         end
         fbfla_pkg::ST_FINISH: begin
            if (kind_ff == fbfla_pkg::REQ_ALLOC) begin
               if (head_ff != fbfla_pkg::FRESH_MARK) begin
                  grant_ok = 1'b1;
                  grant    = head_ff[fbfla_pkg::IDX_W-1:0];
               end else if (fresh_ff < usable) begin
                  grant_ok = 1'b1;
                  grant    = fresh_ff[fbfla_pkg::IDX_W-1:0];
               end else begin
                  status = fbfla_pkg::STATUS_EMPTY;
               end
            end else if (fbfla_pkg::CNT_W'(index_ff) >= usable) begin
               status = fbfla_pkg::STATUS_BAD_INDEX;
            end

            if (out_free) begin
               state_in     = fbfla_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               if (kind_ff == fbfla_pkg::REQ_ALLOC) begin
                  if (grant_ok) begin
                     if (head_ff != fbfla_pkg::FRESH_MARK) begin
                        head_in = rd_data;
                     end else begin
                        fresh_in = fresh_ff + 1'b1;
                     end
                     if (used_ff != fbfla_pkg::USED_MAX) begin
                        used_in = used_ff + 1'b1;
                     end
                  end
               end else if (status == fbfla_pkg::STATUS_OK) begin
                  link_req.wr_en   = 1'b1;
                  link_req.addr    = index_ff;
                  link_req.wr_data = head_ff;
                  head_in          = {1'b0, index_ff};
                  if (used_ff != '0) begin
                     used_in = used_ff - 1'b1;
                  end
               end
               rsp_data_in = {1'b0, used_in, product[fbfla_pkg::OFFS_W-1:0], grant, status};
            end
         end
         default: begin
            state_in = fbfla_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/fbfla_checker.sv
// ----------------------------------------------------------------------------
// Allocator port checker
// Watches the top-level ports of the allocator and flags inconsistent items.
// ----------------------------------------------------------------------------
module fbfla_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [fbfla_pkg::RSP_W-1:0]  rsp_tdata
);

   logic [fbfla_pkg::STATUS_W-1:0] rsp_status;
   logic [fbfla_pkg::RSP_USED_LSB-fbfla_pkg::RSP_GRANT_LSB-1:0] rsp_grant_offs;

   assign rsp_status     = rsp_tdata[fbfla_pkg::RSP_GRANT_LSB-1:fbfla_pkg::RSP_STATUS_LSB];
   assign rsp_grant_offs = rsp_tdata[fbfla_pkg::RSP_USED_LSB-1:fbfla_pkg::RSP_GRANT_LSB];

   // Nothing leaves the block in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result item shown right after reset");

   // Requests are worked one at a time, so an accept closes the input.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in flight");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_status == fbfla_pkg::STATUS_OK ||
                      rsp_status == fbfla_pkg::STATUS_EMPTY ||
                      rsp_status == fbfla_pkg::STATUS_BAD_INDEX))
      else $error("unknown status code");

   // A refused request grants nothing and so carries no offset.
   a_refusal_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status != fbfla_pkg::STATUS_OK) |-> (rsp_grant_offs == '0))
      else $error("refused request carries an index or offset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result item changed or dropped");

endmodule

bind fixed_block_free_list_allocator fbfla_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: tb/sv/fixed_block_free_list_allocator_test.sv
// ----------------------------------------------------------------------------
// Free-list allocator testbench
// Drives allocate and free requests into the block-pool allocator, keeps its
// own model of the free list and checks every returned item field by field.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_test;

   localparam int POOL_MAX    = 256;
   localparam int PHASES      = 11;
   localparam int PHASE_ITEMS = 35;
   localparam int HOLD_AT     = 150;   // requests taken before the long stall
   localparam int HOLD_CYCLES = 200;
   localparam int CALM_FROM   = 300;   // no random idling on either side in this window
   localparam int CALM_TO     = 420;
   localparam int PRINT_MAX   = 40;

   typedef struct packed {
      logic                        op;
      logic [fbfla_pkg::IDX_W-1:0] index;
   } pool_request_type;

   typedef struct packed {
      logic [fbfla_pkg::STATUS_W-1:0] status;
      logic [fbfla_pkg::IDX_W-1:0]    grant;
      logic [fbfla_pkg::OFFS_W-1:0]   offset;
      logic [fbfla_pkg::CNT_W-1:0]    used;
   } pool_answer_type;

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic                         req_tuser  = fbfla_pkg::REQ_ALLOC;
   logic [fbfla_pkg::IDX_W-1:0]  req_tdata  = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [fbfla_pkg::RSP_W-1:0]  rsp_tdata;
   logic                         csr_valid  = 1'b0;
   logic                         csr_ready;
   logic                         csr_index  = fbfla_pkg::CSR_OBJECT_SIZE;
   logic [fbfla_pkg::SIZE_W-1:0] csr_data   = '0;

   // Model of the pool
   logic [fbfla_pkg::LINK_W-1:0] next_link [POOL_MAX];
   logic [fbfla_pkg::LINK_W-1:0] free_head;
   logic [fbfla_pkg::LINK_W-1:0] fresh_count;
   logic [fbfla_pkg::CNT_W-1:0]  in_use;
   logic [fbfla_pkg::SIZE_W-1:0] block_bytes;
   logic [fbfla_pkg::CNT_W-1:0]  pool_blocks;
   logic [fbfla_pkg::IDX_W-1:0]  held_blocks [$];

   pool_request_type pending_reqs [$];
   pool_answer_type  answers_due [$];

   logic req_taken  = 1'b0;
   logic stall_done = 1'b0;
   int   stall_left = 0;
   int   requests_taken = 0;
   int   results_seen = 0;
   int   mismatches = 0;
   int   outcome_count [3] = '{0, 0, 0};
   int   peak_in_use = 0;
   logic calm;

   assign calm = requests_taken >= CALM_FROM && requests_taken < CALM_TO;

   fixed_block_free_list_allocator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
      if (mismatches < PRINT_MAX) begin
         $display("ERROR at %0t: %s, expected %0d, got %0d", $time, what, want, got);
      end
      mismatches++;
   endtask

   // Works out the answer to one request and moves the model on.
   function automatic pool_answer_type serve_request(pool_request_type rq);
      pool_answer_type             ans;
      logic [fbfla_pkg::CNT_W-1:0] limit;
      logic [31:0]                 bytes;
      logic                        granted;
      logic                        found;
      ans     = '0;
      granted = 1'b0;
      found   = 1'b0;
      limit   = (pool_blocks > POOL_MAX) ? fbfla_pkg::CNT_W'(POOL_MAX) : pool_blocks;
      if (rq.op == fbfla_pkg::REQ_ALLOC) begin
         if (free_head < POOL_MAX) begin
            ans.grant = free_head[fbfla_pkg::IDX_W-1:0];
            free_head = next_link[free_head[fbfla_pkg::IDX_W-1:0]];
            granted   = 1'b1;
         end else if (fresh_count < limit) begin
            ans.grant   = fresh_count[fbfla_pkg::IDX_W-1:0];
            fresh_count = fresh_count + 1'b1;
            granted     = 1'b1;
         end
         if (granted) begin
            if (in_use != fbfla_pkg::USED_MAX) in_use = in_use + 1'b1;
            bytes      = 32'(ans.grant) * 32'(block_bytes);
            ans.offset = bytes[fbfla_pkg::OFFS_W-1:0];
            held_blocks.push_back(ans.grant);
         end else begin
            ans.status = fbfla_pkg::STATUS_EMPTY;
         end
      end else if (rq.index >= limit) begin
         ans.status = fbfla_pkg::STATUS_BAD_INDEX;
      end else begin
         next_link[rq.index] = free_head;
         free_head = {1'b0, rq.index};
         if (in_use != 0) in_use = in_use - 1'b1;
         for (int k = 0; k < held_blocks.size(); k++) begin
            if (!found && held_blocks[k] == rq.index) begin
               held_blocks.delete(k);
               found = 1'b1;
            end
         end
      end
      ans.used = in_use;
      return ans;
   endfunction

   // Monitor: register writes, returned items and accepted requests, all
   // taken from the values present just before the rising edge.
   always @(posedge clock) begin : watch
      pool_answer_type  want;
      pool_answer_type  seen;
      pool_request_type rq;
      req_taken <= req_tvalid && req_tready;
      if (reset) begin
         free_head   = fbfla_pkg::FRESH_MARK;
         fresh_count = '0;
         in_use      = '0;
         block_bytes = fbfla_pkg::SIZE_W'(8);
         pool_blocks = fbfla_pkg::CNT_W'(256);
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == fbfla_pkg::CSR_OBJECT_SIZE) block_bytes = csr_data;
            else pool_blocks = csr_data[fbfla_pkg::CNT_W-1:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.status = rsp_tdata[fbfla_pkg::RSP_STATUS_LSB +: fbfla_pkg::STATUS_W];
            seen.grant  = rsp_tdata[fbfla_pkg::RSP_GRANT_LSB +: fbfla_pkg::IDX_W];
            seen.offset = rsp_tdata[fbfla_pkg::RSP_OFFS_LSB +: fbfla_pkg::OFFS_W];
            seen.used   = rsp_tdata[fbfla_pkg::RSP_USED_LSB +: fbfla_pkg::CNT_W];
            results_seen++;
            if (answers_due.size() == 0) begin
               flag_mismatch("item returned with nothing outstanding, status", 0, seen.status);
            end else begin
               want = answers_due.pop_front();
               outcome_count[want.status]++;
               if (seen.status != want.status)
                  flag_mismatch("status", want.status, seen.status);
               if (seen.grant != want.grant)
                  flag_mismatch("granted_index", want.grant, seen.grant);
               if (seen.offset != want.offset)
                  flag_mismatch("block_offset", want.offset, seen.offset);
               if (seen.used != want.used)
                  flag_mismatch("used_count", want.used, seen.used);
            end
         end
         if (req_tvalid && req_tready) begin
            rq.op    = req_tuser;
            rq.index = req_tdata;
            requests_taken++;
            answers_due.push_back(serve_request(rq));
            if (in_use > peak_in_use) peak_in_use = in_use;
         end
      end
   end

   // Request driver: holds the current item until it is taken.
   always @(negedge clock) begin : send
      pool_request_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
            nxt = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= nxt.op;
            req_tdata  <= nxt.index;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // One long hold-off on the result side, so that the block fills and
   // pushes back on its input.
   always @(negedge clock) begin
      if (reset) begin
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (!stall_done && requests_taken >= HOLD_AT) begin
         stall_left <= HOLD_CYCLES;
         stall_done <= 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= stall_left == 0 && (calm || $urandom_range(0, 99) >= 20);
   end

   function automatic void post(logic op, logic [fbfla_pkg::IDX_W-1:0] index);
      pool_request_type rq;
      rq.op    = op;
      rq.index = index;
      pending_reqs.push_back(rq);
   endfunction

   task automatic write_reg(logic which, int unsigned value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data  <= fbfla_pkg::SIZE_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Waits until every request has gone in and every item has come back.
   task automatic settle();
      while (pending_reqs.size() != 0 || req_tvalid || answers_due.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin : stimulus
      int                          roll;
      int                          pick;
      int unsigned                 size_val;
      int unsigned                 count_val;
      int unsigned                 gen_limit;
      logic [fbfla_pkg::IDX_W-1:0] spare [$];
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Pops from fresh issue and from the list, at the reset settings.
      post(fbfla_pkg::REQ_ALLOC, 8'hFF);
      post(fbfla_pkg::REQ_ALLOC, 8'h00);
      post(fbfla_pkg::REQ_FREE, 8'd1);
      post(fbfla_pkg::REQ_FREE, 8'd0);
      post(fbfla_pkg::REQ_ALLOC, 8'h5A);
      post(fbfla_pkg::REQ_ALLOC, 8'hA5);
      post(fbfla_pkg::REQ_ALLOC, 8'h0F);
      settle();

      // An object size of 4096, a tiny pool: exhaustion and bad indices.
      write_reg(fbfla_pkg::CSR_OBJECT_SIZE, 4096);
      write_reg(fbfla_pkg::CSR_OBJECT_COUNT, 4);
      post(fbfla_pkg::REQ_ALLOC, 8'hF0);
      post(fbfla_pkg::REQ_ALLOC, 8'h00);
      post(fbfla_pkg::REQ_FREE, 8'd200);
      post(fbfla_pkg::REQ_FREE, 8'd4);
      post(fbfla_pkg::REQ_FREE, 8'd3);
      post(fbfla_pkg::REQ_FREE, 8'd2);
      settle();

      // A lowered count stops fresh issue but the list still hands out.
      write_reg(fbfla_pkg::CSR_OBJECT_COUNT, 1);
      post(fbfla_pkg::REQ_ALLOC, 8'h00);
      post(fbfla_pkg::REQ_ALLOC, 8'hFF);
      post(fbfla_pkg::REQ_ALLOC, 8'h80);
      post(fbfla_pkg::REQ_FREE, 8'd1);
      post(fbfla_pkg::REQ_FREE, 8'd0);
      settle();

      // A zero count refuses every free; only the list can still hand out.
      write_reg(fbfla_pkg::CSR_OBJECT_SIZE, 8191);
      write_reg(fbfla_pkg::CSR_OBJECT_COUNT, 0);
      post(fbfla_pkg::REQ_ALLOC, 8'h33);
      post(fbfla_pkg::REQ_FREE, 8'd0);
      settle();

      // Random phases: well-formed frees of blocks actually held, mixed with
      // allocates and some frees beyond the pool.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       begin size_val = 8;                       count_val = 256; end
            1:       begin size_val = 4096;                    count_val = 256; end
            2:       begin size_val = $urandom_range(8, 4096); count_val = 2; end
            3:       begin size_val = $urandom_range(8, 4096); count_val = $urandom_range(1, 256); end
            4:       begin size_val = $urandom_range(0, 8191); count_val = 300; end
            5:       begin size_val = 4096;                    count_val = 1; end
            6:       begin size_val = $urandom_range(8, 4096); count_val = 256; end
            7:       begin size_val = 0;                       count_val = $urandom_range(1, 16); end
            8:       begin size_val = $urandom_range(0, 8191); count_val = $urandom_range(0, 8); end
            default: begin size_val = $urandom_range(0, 8191); count_val = $urandom_range(1, 511); end
         endcase
         write_reg(fbfla_pkg::CSR_OBJECT_SIZE, size_val);
         write_reg(fbfla_pkg::CSR_OBJECT_COUNT, count_val);
         gen_limit = (count_val > POOL_MAX) ? POOL_MAX : count_val;
         spare = held_blocks;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 10 && gen_limit < POOL_MAX) begin
               post(fbfla_pkg::REQ_FREE,
                    fbfla_pkg::IDX_W'($urandom_range(gen_limit, POOL_MAX - 1)));
            end else if (spare.size() != 0 && roll >= ((phase % 2) ? 40 : 70)) begin
               pick = $urandom_range(0, spare.size() - 1);
               post(fbfla_pkg::REQ_FREE, spare[pick]);
               spare.delete(pick);
            end else begin
               post(fbfla_pkg::REQ_ALLOC, fbfla_pkg::IDX_W'($urandom_range(0, POOL_MAX - 1)));
            end
         end
         settle();
      end

      // Last of all, since it corrupts the list for good: return every held
      // block, free the top index at zero in use, then free one block twice
      // so that the list loops on itself and keeps handing out that block.
      write_reg(fbfla_pkg::CSR_OBJECT_COUNT, 256);
      write_reg(fbfla_pkg::CSR_OBJECT_SIZE, 8191);
      spare = held_blocks;
      while (spare.size() != 0) post(fbfla_pkg::REQ_FREE, spare.pop_front());
      post(fbfla_pkg::REQ_FREE, 8'd255);
      post(fbfla_pkg::REQ_ALLOC, 8'h00);
      post(fbfla_pkg::REQ_FREE, 8'd0);
      post(fbfla_pkg::REQ_FREE, 8'd0);
      repeat (30) post(fbfla_pkg::REQ_ALLOC, fbfla_pkg::IDX_W'($urandom_range(0, POOL_MAX - 1)));
      settle();
      repeat (10) @(posedge clock);

      $display("Checked %0d items against %0d requests, peak blocks in use %0d.",
               results_seen, requests_taken, peak_in_use);
      $display("Outcomes: %0d granted or freed, %0d pool empty, %0d bad index.",
               outcome_count[fbfla_pkg::STATUS_OK], outcome_count[fbfla_pkg::STATUS_EMPTY],
               outcome_count[fbfla_pkg::STATUS_BAD_INDEX]);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches.", mismatches);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Timed out with %0d items outstanding.", answers_due.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
